// ===== src/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned INDEX_W = 9;
    localparam int unsigned CP_W    = 21;

    localparam logic [CP_W-1:0] CP_MIN_MULTI = 21'h000080;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_SUPP      = 21'h010000;
    localparam logic [CP_W-1:0] CP_LIMIT     = 21'h110000;

    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic [INDEX_W-1:0] unit_index;
        logic [1:0]         status;
        logic               end_of_string;
        logic               last_of_byte;
    } res_t;

    // zero, one or two results produced by one byte
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } dec_out_t;

endpackage

`default_nettype wire

// ===== src/u8u16_decode.sv =====
`default_nettype none

module u8u16_decode #(
    parameter int unsigned BUF_UNITS = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          in_byte,
    output u8u16_pkg::dec_out_t      dec_out
);
    import u8u16_pkg::*;

    localparam int unsigned IDX_W = $clog2(BUF_UNITS + 1);
    localparam logic [IDX_W-1:0] BUF_MAX = IDX_W'(BUF_UNITS);

    logic [CP_W-1:0]  partial_reg, partial_next;
    logic [1:0]       remain_reg, remain_next;
    logic [IDX_W-1:0] widx_reg, widx_next;

    logic [CP_W-1:0]  acc_p;
    logic [CP_W-1:0]  cp_off;
    logic             ovf0, ovf1, bad_cp;
    logic [IDX_W-1:0] idx1, idx2;
    logic [IDX_W+INDEX_W-1:0] ext0, ext1;
    logic [INDEX_W-1:0] uidx0, uidx1;
    res_t             err_res;

    always_comb
    begin
        acc_p  = {partial_reg[CP_W-7:0], in_byte[5:0]};
        cp_off = acc_p - CP_SUPP;
        bad_cp = (acc_p < CP_MIN_MULTI) || ((acc_p >= CP_SURR_LO) && (acc_p <= CP_SURR_HI))
                 || (acc_p >= CP_LIMIT);
        // saturating positions of the first and second unit
        ovf0 = (widx_reg >= BUF_MAX);
        idx1 = ovf0 ? widx_reg : widx_reg + IDX_W'(1);
        ovf1 = (idx1 >= BUF_MAX);
        idx2 = ovf1 ? idx1 : idx1 + IDX_W'(1);
        ext0 = (IDX_W+INDEX_W)'(widx_reg);
        ext1 = (IDX_W+INDEX_W)'(idx1);
        uidx0 = ext0[INDEX_W-1:0];
        uidx1 = ext1[INDEX_W-1:0];

        err_res.code_unit     = '0;
        err_res.unit_index    = uidx0;
        err_res.status        = ST_INVALID;
        err_res.end_of_string = 1'b1;
        err_res.last_of_byte  = 1'b1;

        partial_next = partial_reg;
        remain_next  = remain_reg;
        widx_next    = widx_reg;

        dec_out                  = '0;
        dec_out.r0.unit_index    = uidx0;
        dec_out.r0.status        = ovf0 ? ST_OVERFLOW : ST_OK;
        dec_out.r0.last_of_byte  = 1'b1;
        dec_out.r1.unit_index    = uidx1;
        dec_out.r1.status        = ovf1 ? ST_OVERFLOW : ST_OK;
        dec_out.r1.last_of_byte  = 1'b1;

        if (accept)
        begin
            if (remain_reg == 2'd0)
            begin
                priority if (in_byte == 8'h00)
                begin
                    // terminator: unit 0, then restart the string
                    dec_out.cnt              = 2'd1;
                    dec_out.r0.end_of_string = 1'b1;
                    widx_next                = '0;
                    partial_next             = '0;
                end
                else if (!in_byte[7])
                begin
                    dec_out.cnt          = 2'd1;
                    dec_out.r0.code_unit = {8'h00, in_byte};
                    widx_next            = idx1;
                end
                else if (in_byte[7:5] == 3'b110)
                begin
                    partial_next = {16'h0000, in_byte[4:0]};
                    remain_next  = 2'd1;
                end
                else if (in_byte[7:4] == 4'b1110)
                begin
                    partial_next = {17'h00000, in_byte[3:0]};
                    remain_next  = 2'd2;
                end
                else if (in_byte[7:3] == 5'b11110)
                begin
                    partial_next = {18'h00000, in_byte[2:0]};
                    remain_next  = 2'd3;
                end
                else
                begin
                    dec_out.cnt  = 2'd1;
                    dec_out.r0   = err_res;
                    partial_next = '0;
                    widx_next    = '0;
                end
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                dec_out.cnt  = 2'd1;
                dec_out.r0   = err_res;
                partial_next = '0;
                remain_next  = 2'd0;
                widx_next    = '0;
            end
            else
            begin
                remain_next = remain_reg - 2'd1;
                if (remain_reg != 2'd1)
                begin
                    partial_next = acc_p;
                end
                else
                begin
                    partial_next = '0;
                    priority if (bad_cp)
                    begin
                        dec_out.cnt = 2'd1;
                        dec_out.r0  = err_res;
                        widx_next   = '0;
                    end
                    else if (acc_p < CP_SUPP)
                    begin
                        dec_out.cnt          = 2'd1;
                        dec_out.r0.code_unit = acc_p[UNIT_W-1:0];
                        widx_next            = idx1;
                    end
                    else
                    begin
                        // surrogate pair, high unit first
                        dec_out.cnt             = 2'd2;
                        dec_out.r0.code_unit    = HI_SURR_BASE | {6'h00, cp_off[19:10]};
                        dec_out.r0.last_of_byte = 1'b0;
                        dec_out.r1.code_unit    = LO_SURR_BASE | {6'h00, cp_off[9:0]};
                        widx_next               = idx2;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= '0;
            widx_reg    <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
            widx_reg    <= widx_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/u8u16_outq.sv =====
`default_nettype none

module u8u16_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire u8u16_pkg::dec_out_t dec_out,
    output logic                     space,
    output logic                     valid,
    input  wire logic                ready,
    output u8u16_pkg::res_t          head
);
    import u8u16_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    res_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr1;

    // room for a surrogate pair whatever the sink does this cycle
    assign space   = (count_reg <= (PTR_W+1)'(DEPTH - 2));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign pop     = valid && ready;
    assign wr_ptr1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next = count_reg + (PTR_W+1)'(dec_out.cnt) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (dec_out.cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= dec_out.r0;
        end
        if (dec_out.cnt == 2'd2)
        begin
            entry_reg[wr_ptr1] <= dec_out.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(dec_out.cnt);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/utf8_to_utf16_stream_decoder.sv =====
`default_nettype none

// channel   dir  tdata                                   tuser                        tlast
// s_axis    in   [7:0] in_byte                           -                            -
// m_axis    out  [15:0] code_unit, [24:16] unit_index    [1:0] status,                end_of_string
//                (padded to 32 bits)                     [2] last_of_byte
//
// one byte is taken per cycle while the queue has room and is decoded in the same cycle
// into a four-beat result queue; a byte that completes a supplementary code point yields
// two beats; with a sink that never stalls the queue always has room, input is held back
// only while sink stalls leave three or more beats waiting
// decoded results pass through the queue registers before they reach m_axis
// rst_n clears the decoder state, the buffer position and the queue
// s_axis_tready depends only on the queue fill, never on m_axis_tready
module utf8_to_utf16_stream_decoder #(
    parameter int unsigned BUF_UNITS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] code_unit, [24:16] unit_index
    output logic [2:0]       m_axis_tuser,   // [1:0] status, [2] last_of_byte
    output logic             m_axis_tlast    // end_of_string
);
    import u8u16_pkg::*;

    dec_out_t dec_out;
    res_t     head;
    logic     accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    u8u16_decode #(
        .BUF_UNITS(BUF_UNITS)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .dec_out (dec_out)
    );

    u8u16_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .dec_out (dec_out),
        .space   (s_axis_tready),
        .valid   (m_axis_tvalid),
        .ready   (m_axis_tready),
        .head    (head)
    );

    assign m_axis_tdata = {7'h00, head.unit_index, head.code_unit};
    assign m_axis_tuser = {head.last_of_byte, head.status};
    assign m_axis_tlast = head.end_of_string;

endmodule

`default_nettype wire

// ===== sim/tb_utf8_to_utf16_stream_decoder.sv =====
`default_nettype none

module tb_utf8_to_utf16_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int unsigned BUF_UNITS = 256;
    localparam int unsigned RANDOM_BYTES = 1600;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    utf8_to_utf16_stream_decoder #(
        .BUF_UNITS(BUF_UNITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [7:0] tx_bytes[$];
    res_t       pending_units[$];
    int unsigned n_mismatch = 0;

    // decoder state mirrored by the testbench
    logic [20:0] dec_cp = '0;
    logic [1:0]  dec_left = '0;
    int unsigned dec_wr = 0;

    function automatic void push_unit(logic [15:0] unit, logic eos, logic last);
        res_t r;
        r.code_unit     = unit;
        r.unit_index    = dec_wr[8:0];
        r.status        = (dec_wr >= BUF_UNITS) ? ST_OVERFLOW : ST_OK;
        r.end_of_string = eos;
        r.last_of_byte  = last;
        pending_units.push_back(r);
        if (dec_wr < BUF_UNITS)
            dec_wr++;
    endfunction

    function automatic void push_invalid();
        res_t r;
        r.code_unit     = '0;
        r.unit_index    = dec_wr[8:0];
        r.status        = ST_INVALID;
        r.end_of_string = 1'b1;
        r.last_of_byte  = 1'b1;
        pending_units.push_back(r);
        dec_cp   = '0;
        dec_left = '0;
        dec_wr   = 0;
    endfunction

    function automatic void utf16_of_byte(logic [7:0] b);
        logic [20:0] cp;
        if (dec_left == 2'd0)
        begin
            if (b == 8'h00)
            begin
                push_unit(16'h0000, 1'b1, 1'b1);
                dec_cp = '0;
                dec_wr = 0;
            end
            else if (b < 8'h80)
                push_unit({8'h00, b}, 1'b0, 1'b1);
            else if (b[7:5] == 3'b110)
            begin
                dec_cp   = {16'd0, b[4:0]};
                dec_left = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                dec_cp   = {17'd0, b[3:0]};
                dec_left = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                dec_cp   = {18'd0, b[2:0]};
                dec_left = 2'd3;
            end
            else
                push_invalid();
        end
        else if (b[7:6] != 2'b10)
            push_invalid();
        else
        begin
            dec_cp   = {dec_cp[14:0], b[5:0]};
            dec_left = dec_left - 2'd1;
            if (dec_left == 2'd0)
            begin
                cp     = dec_cp;
                dec_cp = '0;
                if (cp < CP_MIN_MULTI || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                    || cp >= CP_LIMIT)
                    push_invalid();
                else if (cp < CP_SUPP)
                    push_unit(cp[15:0], 1'b0, 1'b1);
                else
                begin
                    cp = cp - CP_SUPP;
                    push_unit(HI_SURR_BASE | {6'd0, cp[19:10]}, 1'b0, 1'b0);
                    push_unit(LO_SURR_BASE | {6'd0, cp[9:0]}, 1'b0, 1'b1);
                end
            end
        end
    endfunction

    // encode in exactly len bytes, so short values give overlong forms
    function automatic void push_char(logic [20:0] cp, int unsigned len);
        unique case (len)
            1: tx_bytes.push_back({1'b0, cp[6:0]});
            2:
            begin
                tx_bytes.push_back({3'b110, cp[10:6]});
                tx_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                tx_bytes.push_back({4'b1110, cp[15:12]});
                tx_bytes.push_back({2'b10, cp[11:6]});
                tx_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                tx_bytes.push_back({5'b11110, cp[20:18]});
                tx_bytes.push_back({2'b10, cp[17:12]});
                tx_bytes.push_back({2'b10, cp[11:6]});
                tx_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void push_random_char(bit clean);
        int unsigned kind;
        logic [20:0] cp;
        kind = clean ? $urandom_range(0, 89) : $urandom_range(0, 99);
        if (kind < 40)
            push_char(21'($urandom_range(1, 8'h7F)), 1);
        else if (kind < 60)
            push_char(21'($urandom_range(12'h080, 12'h7FF)), 2);
        else if (kind < 75)
        begin
            cp = 21'($urandom_range(16'h0800, 16'hFFFF));
            // mostly step out of the surrogate range, sometimes keep it outside clean strings
            if (cp >= CP_SURR_LO && cp <= CP_SURR_HI && (clean || $urandom_range(0, 4) != 0))
                cp = cp ^ 21'h004000;
            push_char(cp, 3);
        end
        else if (kind < 90)
            push_char(21'($urandom_range(21'h010000, 21'h10FFFF)), 4);
        else if (kind < 94)
            push_char(21'($urandom_range(0, 12'h7FF)), $urandom_range(2, 4));
        else if (kind < 97)
            push_char(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        else
            tx_bytes.push_back(8'($urandom_range(1, 255)));
    endfunction

    function automatic void push_broken_seq();
        int unsigned tail;
        int unsigned k;
        logic [7:0] r;
        tail = $urandom_range(1, 3);
        r    = 8'($urandom);
        unique case (tail)
            1: tx_bytes.push_back({3'b110, r[4:0]});
            2: tx_bytes.push_back({4'b1110, r[3:0]});
            default: tx_bytes.push_back({5'b11110, r[2:0]});
        endcase
        k = $urandom_range(0, tail - 1);
        repeat (k) tx_bytes.push_back({2'b10, 6'($urandom)});
        if ($urandom_range(0, 1) == 0)
            tx_bytes.push_back(8'($urandom_range(0, 8'h7F)));
        else
            tx_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
    endfunction

    // sender: bursts with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                utf16_of_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (tx_bytes.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= tx_bytes.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern renewed each time the 6-bit phase counter wraps, sometimes no stalls at all
    logic [15:0] stall_pat = '1;
    logic [5:0]  stall_ph = '0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_ph      <= '0;
        end
        else
        begin
            stall_ph <= stall_ph + 6'd1;
            if (stall_ph == 6'd0)
                stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            m_axis_tready <= stall_pat[stall_ph[3:0]];
        end
    end

    res_t got_unit;
    res_t want_unit;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_unit.code_unit     = m_axis_tdata[15:0];
            got_unit.unit_index    = m_axis_tdata[24:16];
            got_unit.status        = m_axis_tuser[1:0];
            got_unit.end_of_string = m_axis_tlast;
            got_unit.last_of_byte  = m_axis_tuser[2];
            if (pending_units.size() == 0)
            begin
                if (n_mismatch < 10)
                    $display("%0t: unexpected beat unit=%h idx=%0d st=%0d eos=%b last=%b",
                             $realtime, got_unit.code_unit, got_unit.unit_index,
                             got_unit.status, got_unit.end_of_string,
                             got_unit.last_of_byte);
                n_mismatch++;
            end
            else
            begin
                want_unit = pending_units.pop_front();
                if (got_unit.code_unit !== want_unit.code_unit
                    || got_unit.unit_index !== want_unit.unit_index
                    || got_unit.status !== want_unit.status
                    || got_unit.end_of_string !== want_unit.end_of_string
                    || got_unit.last_of_byte !== want_unit.last_of_byte)
                begin
                    if (n_mismatch < 10)
                        $display({"%0t: mismatch exp unit=%h idx=%0d st=%0d eos=%b last=%b",
                                  " got unit=%h idx=%0d st=%0d eos=%b last=%b"}, $realtime,
                                 want_unit.code_unit, want_unit.unit_index, want_unit.status,
                                 want_unit.end_of_string, want_unit.last_of_byte,
                                 got_unit.code_unit, got_unit.unit_index, got_unit.status,
                                 got_unit.end_of_string, got_unit.last_of_byte);
                    n_mismatch++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int unsigned target;
        int unsigned nchar;
        int unsigned term;
        bit          long_str;
        bit          first_str;

        // ascii extremes, the shortest two-byte form and the longest three- and four-byte forms
        push_char(21'h000001, 1);
        push_char(21'h00007F, 1);
        push_char(21'h000080, 2);
        push_char(21'h00FFFF, 3);
        push_char(21'h10FFFF, 4);
        tx_bytes.push_back(8'h00);
        // bad lead bytes
        tx_bytes.push_back(8'h80);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'hF8);
        // overlong below 0x80, surrogate, beyond the last plane
        push_char(21'h000000, 2);
        push_char(21'h00D800, 3);
        push_char(21'h110000, 4);
        // terminator and ascii where a trailing byte belongs
        tx_bytes.push_back(8'hC2);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hE0);
        tx_bytes.push_back(8'h41);

        target    = tx_bytes.size() + RANDOM_BYTES;
        first_str = 1'b1;
        while (tx_bytes.size() < target)
        begin
            // long clean strings run past the end of the buffer
            long_str  = first_str || ($urandom_range(0, 29) == 0);
            first_str = 1'b0;
            nchar     = long_str ? $urandom_range(260, 320) : $urandom_range(0, 24);
            repeat (nchar) push_random_char(long_str);
            term = $urandom_range(0, 9);
            if (term < 8)
                tx_bytes.push_back(8'h00);
            else if (term == 8)
                tx_bytes.push_back(($urandom_range(0, 1) == 0) ?
                                   8'($urandom_range(8'h80, 8'hBF)) :
                                   8'($urandom_range(8'hF8, 8'hFF)));
            else
                push_broken_seq();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (n_mismatch == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
